// ===== hw/rtl/cdeq_pkg.sv =====
// cdeq_pkg: sizes, types, request and status codes and index helpers
// for the circular double-ended queue core; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package cdeq_pkg;

    localparam int DEPTH = 8;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic signed [31:0] t_word;
    typedef logic [2:0]         t_mode;
    typedef logic [1:0]         t_status;

    localparam t_mode MODE_PUSH_FRONT = 3'd0;
    localparam t_mode MODE_PUSH_BACK  = 3'd1;
    localparam t_mode MODE_POP_FRONT  = 3'd2;
    localparam t_mode MODE_POP_BACK   = 3'd3;
    localparam t_mode MODE_PEEK       = 3'd4;

    localparam t_status ST_DONE      = 2'd0;
    localparam t_status ST_OVERFLOW  = 2'd1;
    localparam t_status ST_UNDERFLOW = 2'd2;

    localparam t_word NONE_VALUE = -32'sd1;

    localparam t_idx LAST_IDX = IDX_W'(DEPTH - 1);

    // circular successor
    function automatic t_idx f_next_idx(input t_idx idx);
        t_idx res;
        if (idx == LAST_IDX) begin
            res = '0;
        end else begin
            res = idx + t_idx'(1);
        end
        return res;
    endfunction

    // circular predecessor
    function automatic t_idx f_prev_idx(input t_idx idx);
        t_idx res;
        if (idx == '0) begin
            res = LAST_IDX;
        end else begin
            res = idx - t_idx'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/circular_double_ended_queue_core.sv =====
// circular_double_ended_queue_core: deque of cdeq_pkg::DEPTH 32-bit entries
// in a circular slot memory; depends on cdeq_pkg
`timescale 1ns / 1ps
`default_nettype none

// Fixed-capacity double-ended queue. Each request pushes at the front or
// back, pops from the front or back, or only peeks (unused mode codes act
// as peek). Every request gives exactly one result: a status (done,
// overflow on push into a full deque, underflow on pop from an empty one),
// the popped value (-1 when nothing was removed), the front and back values
// after the request (-1 when empty) and empty/full flags. Entries live in
// a synchronous slot memory with one write and one registered read port;
// the current front and back values are also held in registers, so a
// push, a peek, a rejected request or the pop of the last element has its
// result registered at acceptance and shown in the cycle after it, and the
// next request can be taken as that result is taken. A pop that leaves
// elements behind must fetch the new front or back entry from the slot
// memory into r_rd_data, then fill the result from it. Requests are taken
// whenever the core is not waiting on that memory read and the result
// register is empty or being taken in the same cycle. There is no clearing
// pass after reset; the deque is empty at once.
module circular_double_ended_queue_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // request channel
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire cdeq_pkg::t_mode  i_mode,
    input  wire cdeq_pkg::t_word  i_data_in,
    // result channel
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output cdeq_pkg::t_status     o_status,
    output cdeq_pkg::t_word       o_popped_value,
    output cdeq_pkg::t_word       o_front_value,
    output cdeq_pkg::t_word       o_back_value,
    output logic                  o_is_empty,
    output logic                  o_is_full
);
    import cdeq_pkg::*;

    // sequencer: idle, or waiting on the slot memory read
    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic    r_state;

    // deque bookkeeping
    t_idx    r_head;
    t_idx    r_tail;
    logic    r_empty;
    t_word   r_front;      // cached copy of slot at r_head
    t_word   r_back;       // cached copy of slot at r_tail

    // slot memory and its registered read data
    t_word   r_slots [DEPTH];
    t_word   r_rd_data;
    logic    r_rd_front;   // pending read refills the front (else the back)

    // result register
    logic    r_out_valid;
    t_status r_out_status;
    t_word   r_out_popped;
    t_word   r_out_front;
    t_word   r_out_back;
    logic    r_out_empty;
    logic    r_out_full;

    // next state of the request being accepted
    t_idx    n_head;
    t_idx    n_tail;
    logic    n_empty;
    t_word   n_front;
    t_word   n_back;
    logic    n_full;
    t_status n_status;
    t_word   n_popped;

    // memory port controls
    logic    wr_en;
    t_idx    wr_addr;
    logic    rd_en;
    t_idx    rd_addr;
    logic    rd_front;

    logic    full_now;
    logic    out_take;
    logic    in_accept;

    assign out_take   = r_out_valid && !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_accept  = i_in_valid && !o_in_stall;

    assign full_now = !r_empty && (f_next_idx(r_tail) == r_head);

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_empty  = r_empty;
        n_front  = r_front;
        n_back   = r_back;
        n_status = ST_DONE;
        n_popped = NONE_VALUE;
        wr_en    = 1'b0;
        wr_addr  = r_head;
        rd_en    = 1'b0;
        rd_addr  = r_head;
        rd_front = 1'b0;

        if (i_mode inside {MODE_PUSH_FRONT, MODE_PUSH_BACK}) begin
            if (r_empty) begin
                // first element always lands in slot zero
                n_head  = '0;
                n_tail  = '0;
                n_empty = 1'b0;
                n_front = i_data_in;
                n_back  = i_data_in;
                wr_en   = 1'b1;
                wr_addr = '0;
            end else if (full_now) begin
                n_status = ST_OVERFLOW;
            end else if (i_mode == MODE_PUSH_FRONT) begin
                n_head  = f_prev_idx(r_head);
                n_front = i_data_in;
                wr_en   = 1'b1;
                wr_addr = f_prev_idx(r_head);
            end else begin
                n_tail  = f_next_idx(r_tail);
                n_back  = i_data_in;
                wr_en   = 1'b1;
                wr_addr = f_next_idx(r_tail);
            end
        end else if (i_mode inside {MODE_POP_FRONT, MODE_POP_BACK}) begin
            if (r_empty) begin
                n_status = ST_UNDERFLOW;
            end else if (i_mode == MODE_POP_FRONT) begin
                n_popped = r_front;
                if (r_head == r_tail) begin
                    // last element gone, indices left as they are
                    n_empty = 1'b1;
                end else begin
                    n_head   = f_next_idx(r_head);
                    rd_en    = 1'b1;
                    rd_addr  = f_next_idx(r_head);
                    rd_front = 1'b1;
                end
            end else begin
                n_popped = r_back;
                if (r_head == r_tail) begin
                    n_empty = 1'b1;
                end else begin
                    n_tail  = f_prev_idx(r_tail);
                    rd_en   = 1'b1;
                    rd_addr = f_prev_idx(r_tail);
                end
            end
        end

        n_full = !n_empty && (f_next_idx(n_tail) == n_head);
    end

    // slot memory: one write port, one registered read port; a read is
    // only issued by a pop, never in the same cycle as a write
    always_ff @(posedge i_clk) begin
        if (in_accept && wr_en) begin
            r_slots[wr_addr] <= i_data_in;
        end
        if (in_accept && rd_en) begin
            r_rd_data <= r_slots[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
            r_rd_front  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_head     <= n_head;
                        r_tail     <= n_tail;
                        r_empty    <= n_empty;
                        r_rd_front <= rd_front;
                        if (rd_en) begin
                            // any earlier result is gone by now
                            r_state     <= S_READ;
                            r_out_valid <= 1'b0;
                        end else begin
                            r_out_valid <= 1'b1;
                        end
                    end else if (out_take) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_READ: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // front/back caches and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_accept) begin
            r_front      <= n_front;
            r_back       <= n_back;
            r_out_status <= n_status;
            r_out_popped <= n_popped;
            r_out_front  <= n_empty ? NONE_VALUE : n_front;
            r_out_back   <= n_empty ? NONE_VALUE : n_back;
            r_out_empty  <= n_empty;
            r_out_full   <= n_full;
        end else if (r_state == S_READ) begin
            // refill whichever end the pop moved
            if (r_rd_front) begin
                r_front     <= r_rd_data;
                r_out_front <= r_rd_data;
            end else begin
                r_back     <= r_rd_data;
                r_out_back <= r_rd_data;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_popped_value = r_out_popped;
    assign o_front_value  = r_out_front;
    assign o_back_value   = r_out_back;
    assign o_is_empty     = r_out_empty;
    assign o_is_full      = r_out_full;

    // a memory wait only follows an accepted request
    a_read_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> $past(in_accept))
        else $error("memory wait without an accepted request");

    // result register is free while the memory read is pending
    a_no_result_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("result register busy during memory wait");

    // an empty result reports no front and no back value
    a_empty_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |->
            (r_out_front == NONE_VALUE && r_out_back == NONE_VALUE && !r_out_full))
        else $error("empty result carries element values");

endmodule

`default_nettype wire
